[hdl/timestamp_ordered_deque_core_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the timestamp ordered deque
// Clocked on clk, disabled during rst.
// ---------------------------------------------------------------------------
`ifndef TIMESTAMP_ORDERED_DEQUE_CORE_ASSERT_SVH
`define TIMESTAMP_ORDERED_DEQUE_CORE_ASSERT_SVH

// same-cycle implication
`define TODQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque check failed");

// next-cycle implication
`define TODQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque check failed");

`endif

[hdl/todq_pkg.sv]
// ---------------------------------------------------------------------------
// todq_pkg
// Shared types and constants of the timestamp ordered deque.
// ---------------------------------------------------------------------------
package todq_pkg;

  localparam int DEPTH_DEF  = 64;
  localparam int SUBSEC_DEF = 1000000000;

  localparam int SEC_W   = 32;
  localparam int SUB_W   = 30;
  localparam int PAY_W   = 32;
  localparam int CNT_W   = 7;
  localparam int SPAN_W  = 62;

  localparam logic [1:0] CMD_INSERT     = 2'd0;
  localparam logic [1:0] CMD_POP_NEWEST = 2'd1;
  localparam logic [1:0] CMD_POP_OLDEST = 2'd2;
  localparam logic [1:0] CMD_QUERY      = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SUB_BAD = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef enum logic [1:0] {
    RD_PREV,
    RD_FIRST,
    RD_LAST
  } rd_sel_t;

  typedef struct packed {
    logic [SEC_W-1:0] sec;
    logic [SUB_W-1:0] sub;
    logic [PAY_W-1:0] pay;
  } entry_t;

  typedef struct packed {
    logic    in_ready;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_shift;
    logic    wr_new;
    logic    pop_take;
    logic    latch_old;
    logic    latch_new;
    logic    mul_en;
    logic    add_en;
    logic    span_zero;
    logic    load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic [1:0] command;
    logic [1:0] status;
    logic       full;
    logic       empty;
    logic       cnt_lt2;
    logic       pos_zero;
    logic       new_before;
    logic       out_free;
  } ctl_stat_t;

endpackage

[hdl/todq_if.sv]
// ---------------------------------------------------------------------------
// todq_req_if / todq_res_if
// Request and result channels of the timestamp ordered deque.
// ---------------------------------------------------------------------------
interface todq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] stamp_seconds;
  logic [29:0] stamp_subseconds;
  logic [31:0] payload;

  modport source (output valid, command, stamp_seconds, stamp_subseconds, payload,
                  input ready);
  modport sink (input valid, command, stamp_seconds, stamp_subseconds, payload,
                output ready);
endinterface

interface todq_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] popped_seconds;
  logic [29:0] popped_subseconds;
  logic [31:0] popped_payload;
  logic [6:0]  entry_count;
  logic [61:0] time_span;

  modport source (output valid, status, popped_seconds, popped_subseconds,
                  popped_payload, entry_count, time_span, input ready);
  modport sink (input valid, status, popped_seconds, popped_subseconds,
                popped_payload, entry_count, time_span, output ready);
endinterface

[hdl/todq_ctrl.sv]
// ---------------------------------------------------------------------------
// todq_ctrl
// Sequencer: insert walk, pop, span computation and result hand-off.
// ---------------------------------------------------------------------------
module todq_ctrl
  import todq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  ctl_stat_t stat,
  output ctl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_WR,
    S_POP_RD,
    S_POP_TAKE,
    S_SP_FIRST,
    S_SP_LAST,
    S_SP_LATCH,
    S_SP_MUL,
    S_SP_ADD,
    S_DONE
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_PREV;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (stat.status != ST_OK || stat.command == CMD_QUERY) begin
          state_next = S_SP_FIRST;
        end else if (stat.command == CMD_INSERT) begin
          state_next = S_INS_RD;
        end else begin
          state_next = S_POP_RD;
        end
      end
      S_INS_RD: begin
        if (stat.pos_zero) begin
          state_next = S_INS_WR;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PREV;
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (stat.new_before) begin
          cmd.wr_shift = 1'b1;
          state_next   = S_INS_RD;
        end else begin
          state_next = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.wr_new = 1'b1;
        state_next = S_SP_FIRST;
      end
      S_POP_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = (stat.command == CMD_POP_NEWEST) ? RD_LAST : RD_FIRST;
        state_next = S_POP_TAKE;
      end
      S_POP_TAKE: begin
        cmd.pop_take = 1'b1;
        state_next   = S_SP_FIRST;
      end
      S_SP_FIRST: begin
        if (stat.cnt_lt2) begin
          cmd.span_zero = 1'b1;
          state_next    = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_FIRST;
          state_next = S_SP_LAST;
        end
      end
      S_SP_LAST: begin
        cmd.latch_old = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.rd_sel    = RD_LAST;
        state_next    = S_SP_LATCH;
      end
      S_SP_LATCH: begin
        cmd.latch_new = 1'b1;
        state_next    = S_SP_MUL;
      end
      S_SP_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = S_SP_ADD;
      end
      S_SP_ADD: begin
        cmd.add_en = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[hdl/todq_datapath.sv]
// ---------------------------------------------------------------------------
// todq_datapath
// Ring-buffer memory kept sorted, counters, span arithmetic, result register.
// ---------------------------------------------------------------------------
module todq_datapath
  import todq_pkg::*;
#(
  parameter int DEPTH          = DEPTH_DEF,
  parameter int SUBSEC_PER_SEC = SUBSEC_DEF
) (
  input  logic       clk,
  input  logic       rst,
  todq_req_if.sink   request,
  todq_res_if.source result,
  input  ctl_cmd_t   cmd,
  output ctl_stat_t  stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t mem [DEPTH];
  entry_t rd_q;
  entry_t item;

  logic [1:0]        command;
  logic [1:0]        status;
  logic [CW-1:0]     count;
  logic [CW-1:0]     pos;
  logic [AW-1:0]     head;
  logic [SEC_W-1:0]  old_sec, new_sec;
  logic [SUB_W-1:0]  old_sub, new_sub;
  logic [SPAN_W-1:0] prod, span;
  entry_t            popped;

  logic [AW-1:0]     rd_addr, wr_addr;
  logic              accept;
  logic              full, empty;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [CW-1:0] l);
    logic [AW:0] s;
    s = {1'b0, base} + (AW+1)'(l);
    if (s >= (AW+1)'(DEPTH)) s = s - (AW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  assign accept = request.valid && request.ready;
  assign full   = (count == CW'(DEPTH));
  assign empty  = (count == '0);
  assign request.ready = cmd.in_ready;

  always_comb begin
    unique case (cmd.rd_sel)
      RD_PREV:  rd_addr = phys(head, CW'(pos - 1'b1));
      RD_FIRST: rd_addr = head;
      RD_LAST:  rd_addr = phys(head, CW'(count - 1'b1));
      default:  rd_addr = head;
    endcase
  end

  assign wr_addr = phys(head, pos);

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rd_q <= mem[rd_addr];
    if (cmd.wr_shift) begin
      mem[wr_addr] <= rd_q;
    end else if (cmd.wr_new) begin
      mem[wr_addr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      head  <= '0;
    end else begin
      if (cmd.wr_new) count <= CW'(count + 1'b1);
      if (cmd.pop_take) begin
        count <= CW'(count - 1'b1);
        if (command == CMD_POP_OLDEST) head <= phys(head, CW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      command   <= request.command;
      item.sec  <= request.stamp_seconds;
      item.sub  <= request.stamp_subseconds;
      item.pay  <= request.payload;
      pos       <= count;
      popped    <= '0;
      priority if (request.command == CMD_INSERT) begin
        if (request.stamp_subseconds > SUB_W'(SUBSEC_PER_SEC - 1)) status <= ST_SUB_BAD;
        else if (full) status <= ST_FULL;
        else status <= ST_OK;
      end else if (request.command == CMD_QUERY) begin
        status <= ST_OK;
      end else begin
        status <= empty ? ST_EMPTY : ST_OK;
      end
    end
    if (cmd.wr_shift) pos <= CW'(pos - 1'b1);
    if (cmd.pop_take) popped <= rd_q;
    if (cmd.latch_old) begin
      old_sec <= rd_q.sec;
      old_sub <= rd_q.sub;
    end
    if (cmd.latch_new) begin
      new_sec <= rd_q.sec;
      new_sub <= rd_q.sub;
    end
    if (cmd.mul_en) begin
      prod <= SPAN_W'({30'd0, SEC_W'(new_sec - old_sec)} * SPAN_W'(SUBSEC_PER_SEC));
    end
    if (cmd.add_en) span <= SPAN_W'(prod + SPAN_W'(new_sub) - SPAN_W'(old_sub));
    if (cmd.span_zero) span <= '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (cmd.load_out) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result.status            <= status;
      result.popped_seconds    <= popped.sec;
      result.popped_subseconds <= popped.sub;
      result.popped_payload    <= popped.pay;
      result.entry_count       <= CNT_W'(count);
      result.time_span         <= span;
    end
  end

  always_comb begin
    stat.in_valid   = request.valid;
    stat.command    = command;
    stat.status     = status;
    stat.full       = full;
    stat.empty      = empty;
    stat.cnt_lt2    = (count < CW'(2));
    stat.pos_zero   = (pos == '0);
    stat.new_before = (item.sec < rd_q.sec) ||
                      ((item.sec == rd_q.sec) && (item.sub < rd_q.sub));
    stat.out_free   = !result.valid || result.ready;
  end

endmodule

[hdl/timestamp_ordered_deque_core.sv]
// ---------------------------------------------------------------------------
// timestamp_ordered_deque_core
// Bounded deque kept sorted by timestamp; insert, pop newest/oldest, query.
// ---------------------------------------------------------------------------
// channel   dir  fields
// request   in   command, stamp_seconds, stamp_subseconds, payload
// result    out  status, popped_*, entry_count, time_span
//
// One request at a time; the next is taken once the last result is loaded into
// the output register. Span (two or more entries): two memory reads, multiply,
// add. A pop reads and takes its entry; an insert walks the single-port memory,
// moving each later-stamped entry up one place, then writes the new entry.
// A finished result waits in the output register while the next request is
// taken. Reset (synchronous) empties the deque at once; no clearing pass.
// ---------------------------------------------------------------------------
`include "timestamp_ordered_deque_core_assert.svh"

module timestamp_ordered_deque_core
  import todq_pkg::*;
#(
  parameter int DEPTH          = DEPTH_DEF,
  parameter int SUBSEC_PER_SEC = SUBSEC_DEF
) (
  input  logic       clk,
  input  logic       rst,
  todq_req_if.sink   request,
  todq_res_if.source result
);

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  todq_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  todq_datapath #(
    .DEPTH          (DEPTH),
    .SUBSEC_PER_SEC (SUBSEC_PER_SEC)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .result  (result),
    .cmd     (cmd),
    .stat    (stat)
  );

  `TODQ_ASSERT_NOW(a_no_write_full, cmd.wr_new, !stat.full)
  `TODQ_ASSERT_NOW(a_no_pop_empty, cmd.pop_take, !stat.empty)
  `TODQ_ASSERT_NOW(a_shift_in_range, cmd.wr_shift, !stat.pos_zero)
  `TODQ_ASSERT_NOW(a_load_free, cmd.load_out, stat.out_free)
  `TODQ_ASSERT_NEXT(a_one_at_a_time, request.valid && request.ready, !request.ready)

endmodule
